// File: rtl/ycbcr420_to_rgb_quad_macros.svh
// assertion macros for the 4:2:0 to rgb quad converter
// used by modules that check their own pipeline control; needs clk and rst in scope
`ifndef YCBCR420_TO_RGB_QUAD_MACROS_SVH
`define YCBCR420_TO_RGB_QUAD_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define YCC_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define YCC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// File: rtl/ycc_pkg.sv
// shared types and constants of the 4:2:0 to rgb quad converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ycc_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int DIFF_W  = PIX_W + 1;   // sample minus offset, signed
  localparam int TERM_W  = 26;          // one coefficient product, signed
  localparam int SUM_W   = 27;          // luma term plus chroma terms, signed
  localparam int FRAC_W  = 16;          // fractional bits of the coefficients
  localparam int SHIFT_W = SUM_W - FRAC_W;
  localparam int LANES   = 4;
  localparam int IN_W    = 6 * PIX_W;
  localparam int OUT_W   = 3 * LANES * PIX_W;

  // bt.601 video range coefficients, 16 fractional bits
  localparam logic signed [TERM_W-1:0] COEF_Y    = TERM_W'(76309);
  localparam logic signed [TERM_W-1:0] COEF_CR_R = TERM_W'(104597);
  localparam logic signed [TERM_W-1:0] COEF_CB_B = TERM_W'(132201);
  localparam logic signed [TERM_W-1:0] COEF_CB_G = TERM_W'(25675);
  localparam logic signed [TERM_W-1:0] COEF_CR_G = TERM_W'(53279);

  // sample offsets
  localparam logic signed [DIFF_W-1:0] LUMA_OFFSET = DIFF_W'(16);
  localparam logic signed [DIFF_W-1:0] CHROMA_MID  = DIFF_W'(128);
  localparam logic [PIX_W-1:0]         PIX_MAX     = PIX_W'(255);

  // chroma products shared by all four lanes
  typedef struct packed {
    logic signed [TERM_W-1:0] red;
    logic signed [TERM_W-1:0] blue;
    logic signed [TERM_W-1:0] green_cb;
    logic signed [TERM_W-1:0] green_cr;
  } chroma_terms_t;

  // one output pixel
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

endpackage

// File: rtl/ycc_chroma.sv
// chroma product stage: the four cb/cr coefficient products, registered
// depends on ycc_pkg
`timescale 1ns / 1ps

module ycc_chroma
  import ycc_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [PIX_W-1:0]   cb,
  input  logic [PIX_W-1:0]   cr,
  output chroma_terms_t      terms
);

  logic signed [DIFF_W-1:0] cb_diff;
  logic signed [DIFF_W-1:0] cr_diff;

  // remove the chroma midpoint
  assign cb_diff = signed'({1'b0, cb}) - CHROMA_MID;
  assign cr_diff = signed'({1'b0, cr}) - CHROMA_MID;

  // one multiplier per product, registered
  always_ff @(posedge clk) begin
    if (load) begin
      terms.red      <= TERM_W'(TERM_W'(cr_diff) * COEF_CR_R);
      terms.blue     <= TERM_W'(TERM_W'(cb_diff) * COEF_CB_B);
      terms.green_cb <= TERM_W'(TERM_W'(cb_diff) * COEF_CB_G);
      terms.green_cr <= TERM_W'(TERM_W'(cr_diff) * COEF_CR_G);
    end
  end

endmodule

// File: rtl/ycc_lane.sv
// one pixel lane: luma product, then sum with chroma terms, shift and clamp
// depends on ycc_pkg
`timescale 1ns / 1ps

module ycc_lane
  import ycc_pkg::*;
(
  input  logic               clk,
  input  logic               load_mul,
  input  logic               load_out,
  input  logic [PIX_W-1:0]   luma,
  input  chroma_terms_t      terms,
  output rgb_t               pix
);

  logic signed [DIFF_W-1:0] y_diff;
  logic signed [TERM_W-1:0] y_term;
  logic signed [SUM_W-1:0]  sum_red;
  logic signed [SUM_W-1:0]  sum_green;
  logic signed [SUM_W-1:0]  sum_blue;

  // floor shift by the fraction width, then clamp to the pixel range
  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] sum);
    logic signed [SHIFT_W-1:0] shifted;
    shifted = sum[SUM_W-1:FRAC_W];
    if (shifted[SHIFT_W-1]) begin
      clamp_pix = '0;
    end else if (|shifted[SHIFT_W-2:PIX_W]) begin
      clamp_pix = PIX_MAX;
    end else begin
      clamp_pix = shifted[PIX_W-1:0];
    end
  endfunction

  assign y_diff = signed'({1'b0, luma}) - LUMA_OFFSET;

  // luma product
  always_ff @(posedge clk) begin
    if (load_mul) begin
      y_term <= TERM_W'(TERM_W'(y_diff) * COEF_Y);
    end
  end

  // color sums
  assign sum_red   = SUM_W'(y_term) + SUM_W'(terms.red);
  assign sum_green = SUM_W'(y_term) - SUM_W'(terms.green_cb) - SUM_W'(terms.green_cr);
  assign sum_blue  = SUM_W'(y_term) + SUM_W'(terms.blue);

  // output register of the lane
  always_ff @(posedge clk) begin
    if (load_out) begin
      pix.red   <= clamp_pix(sum_red);
      pix.green <= clamp_pix(sum_green);
      pix.blue  <= clamp_pix(sum_blue);
    end
  end

endmodule

// File: rtl/ycbcr420_to_rgb_quad.sv
// Converts one 2x2 block of a 4:2:0 picture to four RGB pixels (BT.601,
// video range, fixed-point coefficients with 16 fractional bits, results clamped to 0..255).
//
// Input beat on s_tdata: four luma bytes (top left, top right, bottom left,
// bottom right) then Cb and Cr. Output beat on m_tdata: red, green, blue of
// each pixel in the same pixel order.
//
// An accepted input beat passes two register stages on its way to m_tvalid:
// the multiplier stage for the coefficient products, then the output
// register, which takes the sums and clamps. Four pixel lanes run side by
// side and share the chroma products, so a new beat is taken every cycle
// while m_tready stays high: throughput is one block per cycle.
//
// Each stage has its own valid bit and loads when it is empty or its
// successor moves. When the receiver holds m_tready low the output beat is
// kept stable, and the block still takes one more input beat into the free
// multiplier stage before s_tready drops.
//
// Synchronous reset clears the valid bits only; no beat is in flight after.
`timescale 1ns / 1ps

module ycbcr420_to_rgb_quad
  import ycc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // top_left_red/green/blue, top_right_red/green/blue,
  // bottom_left_red/green/blue, bottom_right_red/green/blue
  output logic [OUT_W-1:0] m_tdata
);

`include "ycbcr420_to_rgb_quad_macros.svh"

  logic          mul_valid;
  logic          mul_load;
  logic          out_load;
  logic          mul_free;
  logic          out_free;
  chroma_terms_t terms;
  rgb_t          pix [LANES];

  // stage control
  assign out_free = !m_tvalid || m_tready;
  assign mul_free = !mul_valid || out_free;
  assign s_tready = mul_free;
  assign mul_load = s_tvalid && mul_free;
  assign out_load = mul_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (mul_free) begin
        mul_valid <= s_tvalid;
      end
      if (out_free) begin
        m_tvalid <= mul_valid;
      end
    end
  end

  // shared chroma products
  ycc_chroma u_chroma (
    .clk   (clk),
    .load  (mul_load),
    .cb    (s_tdata[4*PIX_W +: PIX_W]),
    .cr    (s_tdata[5*PIX_W +: PIX_W]),
    .terms (terms)
  );

  // pixel lanes and merge into the output beat
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ycc_lane u_lane (
      .clk      (clk),
      .load_mul (mul_load),
      .load_out (out_load),
      .luma     (s_tdata[i*PIX_W +: PIX_W]),
      .terms    (terms),
      .pix      (pix[i])
    );
    assign m_tdata[(3*i+0)*PIX_W +: PIX_W] = pix[i].red;
    assign m_tdata[(3*i+1)*PIX_W +: PIX_W] = pix[i].green;
    assign m_tdata[(3*i+2)*PIX_W +: PIX_W] = pix[i].blue;
  end

  // pipeline control checks
  `YCC_ASSERT_SAME(a_full_blocks, mul_valid && m_tvalid && !m_tready, !s_tready, "input taken while both stages are full and stalled")
  `YCC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, mul_valid, "accepted beat did not reach the multiplier stage")
  `YCC_ASSERT_NEXT(a_stall_keeps, mul_valid && m_tvalid && !m_tready, mul_valid, "beat lost from the multiplier stage during a stall")
  `YCC_ASSERT_NEXT(a_advance, mul_valid && (!m_tvalid || m_tready), m_tvalid, "beat did not advance into the output register")

endmodule
